### design/qsde_pkg.sv
// qsde_pkg: shared widths, codes, constants and the queue word type for the
// quadrature speed and distance estimator; no dependencies
`default_nettype none

package qsde_pkg;

	// field widths
	localparam int CPR_W      = 16;
	localparam int CIRC_W     = 24;
	localparam int ENA_W      = 2;
	localparam int COUNTER_W  = 16;
	localparam int MS_W       = 16;
	localparam int DELTA_W    = 16;
	localparam int TOTAL_W    = 32;
	localparam int SPEED_W    = 32;
	localparam int DIST_W     = 48;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// scale factors
	localparam int MRPM_SCALE_W = 26;
	localparam int UMS_SCALE_W  = 10;
	localparam logic [MRPM_SCALE_W-1:0] MRPM_SCALE = 26'd60000000;
	localparam logic [UMS_SCALE_W-1:0]  UMS_SCALE  = 10'd1000;

	// datapath widths
	localparam int DEN_W       = CPR_W + MS_W;
	localparam int MRPM_NUM_W  = DELTA_W + MRPM_SCALE_W;
	localparam int UMS_PROD_W  = DELTA_W + CIRC_W;
	localparam int UMS_NUM_W   = UMS_PROD_W + UMS_SCALE_W;
	localparam int DIST_NUM_W  = TOTAL_W + CIRC_W;
	localparam int MAG_W       = DIST_NUM_W + 1;

	// positive saturation limits
	localparam logic [DIST_W-1:0] LIM32 = 48'h0000_7FFF_FFFF;
	localparam logic [DIST_W-1:0] LIM48 = 48'h7FFF_FFFF_FFFF;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_UPDATED = 2'd0,
		ST_INVALID = 2'd1,
		ST_CLEARED = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CPR    = 2'd0,
		CFG_CIRC   = 2'd1,
		CFG_ENABLE = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_LOAD,
		BK_DIV,
		BK_ROUND,
		BK_SAT,
		BK_OUT
	} back_state_t;

	// classified word passed from front to back
	typedef struct packed {
		status_t                    status;
		logic                       channel;
		logic signed [DELTA_W-1:0]  delta;
		logic signed [TOTAL_W-1:0]  total;
		logic [MS_W-1:0]            interval_ms;
	} job_t;

endpackage

`default_nettype wire

### design/qsde_if.sv
// qsde_if: sample and result channel interfaces (valid/ready plus payload)
// depends on qsde_pkg
`default_nettype none

interface qsde_sample_if import qsde_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic                 channel;
	logic [COUNTER_W-1:0] counter_value;
	logic [MS_W-1:0]      interval_ms;

	modport source (output valid, command, channel, counter_value, interval_ms,
		input ready);
	modport sink (input valid, command, channel, counter_value, interval_ms,
		output ready);
endinterface

interface qsde_result_if import qsde_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic                       result_channel;
	logic signed [DELTA_W-1:0]  count_delta;
	logic signed [TOTAL_W-1:0]  count_total;
	logic signed [SPEED_W-1:0]  speed_milli_rpm;
	logic signed [SPEED_W-1:0]  speed_um_per_s;
	logic signed [DIST_W-1:0]   distance_um;

	modport source (output valid, status, result_channel, count_delta, count_total,
		speed_milli_rpm, speed_um_per_s, distance_um, input ready);
	modport sink (input valid, status, result_channel, count_delta, count_total,
		speed_milli_rpm, speed_um_per_s, distance_um, output ready);
endinterface

`default_nettype wire

### design/quadrature_speed_distance_estimator.sv
// quadrature_speed_distance_estimator: top level with configuration registers,
// front, queue and back; depends on qsde_pkg, qsde_if, qsde_front, qsde_fifo,
// qsde_back
//
// usage:
//  - sample channel: one word per encoder sample or clear (command, channel,
//    counter_value, interval_ms), taken when valid and ready are both high
//  - result channel: exactly one word per sample word, in order
//  - configuration: cfg_wr_en with cfg_index 0 (counts per rev), 1 (wheel
//    circumference in um), 2 (channel enable); write only while idle
//  - an updated sample passes through the product, load, divide, round and
//    saturate stages; the distance divider needs 56 steps (one quotient bit
//    per cycle), and the two speed dividers run alongside
//  - cleared or skipped words bypass the arithmetic and pass from the queue
//    through the job register to the result port; the back end takes the
//    next word from the queue only after the last result is taken
//  - the front keeps accepting while a result waits: a two-word queue sits
//    between front and back, so sample ready drops only when it fills
//  - a stalled result holds in the output registers until it is taken
//  - reset clears snapshots, totals, configuration and the queue
`default_nettype none

module quadrature_speed_distance_estimator import qsde_pkg::*; #(
	parameter int NUM_CHANNELS = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	qsde_sample_if.sink                sample,
	qsde_result_if.source              result,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	// configuration registers
	logic [CPR_W-1:0]  cpr_q;
	logic [CIRC_W-1:0] circ_q;
	logic [ENA_W-1:0]  enable_q;

	// front to queue, queue to back
	logic job_push;
	logic job_full;
	job_t push_data;
	logic pop_valid;
	logic pop_ready;
	job_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q    <= '0;
			circ_q   <= '0;
			enable_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CPR:    cpr_q    <= cfg_wdata[CPR_W-1:0];
				CFG_CIRC:   circ_q   <= cfg_wdata[CIRC_W-1:0];
				CFG_ENABLE: enable_q <= cfg_wdata[ENA_W-1:0];
				default:    ; // unused index, write dropped
			endcase
		end
	end

	// front: per-channel state update and classification
	qsde_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.cpr      (cpr_q),
		.enable   (enable_q),
		.job_full (job_full),
		.job_push (job_push),
		.job_data (push_data)
	);

	// decoupling queue
	qsde_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (push_data),
		.full      (job_full),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// back: products, division, rounding, saturation, result register
	qsde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_data),
		.cpr       (cpr_q),
		.circ      (circ_q),
		.result    (result)
	);

endmodule

`default_nettype wire

### design/qsde_front.sv
// qsde_front: accepts sample words, keeps per-channel snapshot and total,
// classifies each word and pushes it to the queue; depends on qsde_pkg, qsde_if
`default_nettype none

module qsde_front import qsde_pkg::*; #(
	parameter int NUM_CHANNELS = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	qsde_sample_if.sink           sample,
	input  wire logic [CPR_W-1:0] cpr,
	input  wire logic [ENA_W-1:0] enable,
	input  wire logic             job_full,
	output logic                  job_push,
	output job_t                  job_data
);

	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [COUNTER_W-1:0] snap_q  [NUM_CHANNELS];
	logic [TOTAL_W-1:0]   total_q [NUM_CHANNELS];

	logic [CH_IDX_W-1:0]  ch_idx;
	logic                 has_state;
	logic                 enabled;
	logic                 invalid;
	logic                 accept;
	logic                 state_wr;
	logic [COUNTER_W-1:0] cur_snap;
	logic [TOTAL_W-1:0]   cur_total;
	logic [DELTA_W-1:0]   d16;
	logic [TOTAL_W-1:0]   new_total;
	logic [COUNTER_W-1:0] snap_wr;

	assign sample.ready = ~job_full;
	assign accept       = sample.valid & ~job_full;
	assign job_push     = accept;

	always_comb begin
		ch_idx    = CH_IDX_W'(sample.channel);
		has_state = 32'(sample.channel) < NUM_CHANNELS;
		enabled   = has_state && enable[sample.channel];
		cur_snap  = has_state ? snap_q[ch_idx] : '0;
		cur_total = has_state ? total_q[ch_idx] : '0;
		d16       = sample.counter_value - cur_snap;
		new_total = cur_total + {{(TOTAL_W-DELTA_W){d16[DELTA_W-1]}}, d16};
		invalid   = (sample.interval_ms == '0) || (cpr == '0);

		job_data.status      = ST_UPDATED;
		job_data.channel     = sample.channel;
		job_data.delta       = '0;
		job_data.total       = cur_total;
		job_data.interval_ms = sample.interval_ms;
		state_wr             = 1'b0;
		snap_wr              = '0;

		priority if (sample.command == CMD_CLEAR) begin
			job_data.status = ST_CLEARED;
			if (enabled) begin
				job_data.total = '0;
				state_wr       = 1'b1;
			end
		end else if (invalid) begin
			job_data.status = ST_INVALID;
		end else begin
			if (enabled) begin
				job_data.delta = d16;
				job_data.total = new_total;
				snap_wr        = sample.counter_value;
				state_wr       = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				snap_q[i]  <= '0;
				total_q[i] <= '0;
			end
		end else if (accept && state_wr) begin
			snap_q[ch_idx]  <= snap_wr;
			total_q[ch_idx] <= job_data.total;
		end
	end

endmodule

`default_nettype wire

### design/qsde_fifo.sv
// qsde_fifo: short queue of classified words between front and back
// depends on qsde_pkg
`default_nettype none

module qsde_fifo import qsde_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_data,
	output logic      full,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output job_t      pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [OCC_W-1:0] occ_q;
	logic             pop;

	assign full      = occ_q == OCC_W'(QUEUE_DEPTH);
	assign pop_valid = occ_q != '0;
	assign pop       = pop_valid & pop_ready;
	assign pop_data  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			occ_q <= occ_q + OCC_W'(push) - OCC_W'(pop);
		end
	end

endmodule

`default_nettype wire

### design/qsde_div.sv
// qsde_div: restoring unsigned divider, one quotient bit per cycle
// depends on nothing but the clock and reset
`default_nettype none

module qsde_div #(
	parameter int NUM_W = 42,
	parameter int DEN_W = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [NUM_W-1:0]      quo,
	output logic [DEN_W-1:0]      rem
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  acc_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;

	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, acc_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	assign busy = busy_q;
	assign quo  = acc_q;
	assign rem  = rem_q;

	// numerator shifts out at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			acc_q <= {acc_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(NUM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### design/qsde_back.sv
// qsde_back: takes classified words from the queue, forms the products, runs
// three dividers, rounds, saturates and holds the result; depends on qsde_pkg,
// qsde_if, qsde_div
`default_nettype none

module qsde_back import qsde_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	output logic                   job_ready,
	input  job_t                   job,
	input  wire logic [CPR_W-1:0]  cpr,
	input  wire logic [CIRC_W-1:0] circ,
	qsde_result_if.source          result
);

	back_state_t state_q, state_d;
	job_t        job_q;

	logic [MRPM_NUM_W-1:0] prod_mrpm_q;
	logic [UMS_PROD_W-1:0] prod_dc_q;
	logic [DIST_NUM_W-1:0] prod_dist_q;
	logic [DEN_W-1:0]      den_q;
	logic [UMS_NUM_W-1:0]  num_ums;

	logic                  div_start;
	logic                  busy_mrpm, busy_ums, busy_dist;
	logic [MRPM_NUM_W-1:0] quo_mrpm;
	logic [UMS_NUM_W-1:0]  quo_ums;
	logic [DIST_NUM_W-1:0] quo_dist;
	logic [DEN_W-1:0]      rem_mrpm, rem_ums;
	logic [CPR_W-1:0]      rem_dist;

	logic [MRPM_NUM_W:0]   rq_mrpm_q;
	logic [UMS_NUM_W:0]    rq_ums_q;
	logic [DIST_NUM_W:0]   rq_dist_q;

	logic [SPEED_W-1:0]    res_mrpm_q, res_ums_q;
	logic [DIST_W-1:0]     res_dist_q;

	logic                  neg_d, neg_t;
	logic [DELTA_W-1:0]    mag_d;
	logic [TOTAL_W-1:0]    mag_t;
	logic                  up_mrpm, up_ums, up_dist;
	logic [DIST_W-1:0]     sat_mrpm, sat_ums, sat_dist;

	// magnitude clipped to the signed range, returned in two's complement
	function automatic logic [DIST_W-1:0] sat_mag(input logic [MAG_W-1:0] mag,
		input logic neg, input logic [DIST_W-1:0] lim);
		logic [MAG_W-1:0] lim_pos;
		logic [MAG_W-1:0] lim_neg;
		logic [MAG_W-1:0] m;
		lim_pos = MAG_W'(lim);
		lim_neg = lim_pos + 1'b1;
		if (neg) begin
			m = (mag > lim_neg) ? lim_neg : mag;
			m = '0 - m;
		end else begin
			m = (mag > lim_pos) ? lim_pos : mag;
		end
		return m[DIST_W-1:0];
	endfunction

	always_comb begin
		neg_d    = job_q.delta[DELTA_W-1];
		neg_t    = job_q.total[TOTAL_W-1];
		mag_d    = neg_d ? (DELTA_W'(0) - $unsigned(job_q.delta)) : $unsigned(job_q.delta);
		mag_t    = neg_t ? (TOTAL_W'(0) - $unsigned(job_q.total)) : $unsigned(job_q.total);
		num_ums  = UMS_NUM_W'(prod_dc_q) * UMS_NUM_W'(UMS_SCALE);
		up_mrpm  = {rem_mrpm, 1'b0} >= {1'b0, den_q};
		up_ums   = {rem_ums, 1'b0} >= {1'b0, den_q};
		up_dist  = {rem_dist, 1'b0} >= {1'b0, cpr};
		sat_mrpm = sat_mag(MAG_W'(rq_mrpm_q), neg_d, LIM32);
		sat_ums  = sat_mag(MAG_W'(rq_ums_q), neg_d, LIM32);
		sat_dist = sat_mag(MAG_W'(rq_dist_q), neg_t, LIM48);
	end

	qsde_div #(.NUM_W(MRPM_NUM_W), .DEN_W(DEN_W)) u_div_mrpm (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(prod_mrpm_q), .den(den_q),
		.busy(busy_mrpm), .quo(quo_mrpm), .rem(rem_mrpm)
	);

	qsde_div #(.NUM_W(UMS_NUM_W), .DEN_W(DEN_W)) u_div_ums (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_ums), .den(den_q),
		.busy(busy_ums), .quo(quo_ums), .rem(rem_ums)
	);

	qsde_div #(.NUM_W(DIST_NUM_W), .DEN_W(CPR_W)) u_div_dist (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(prod_dist_q), .den(cpr),
		.busy(busy_dist), .quo(quo_dist), .rem(rem_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		job_ready    = 1'b0;
		div_start    = 1'b0;
		result.valid = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid)
					state_d = (job.status == ST_UPDATED) ? BK_MUL : BK_OUT;
			end
			BK_MUL:   state_d = BK_LOAD;
			BK_LOAD: begin
				div_start = 1'b1;
				state_d   = BK_DIV;
			end
			BK_DIV: begin
				if (!busy_mrpm && !busy_ums && !busy_dist)
					state_d = BK_ROUND;
			end
			BK_ROUND: state_d = BK_SAT;
			BK_SAT:   state_d = BK_OUT;
			BK_OUT: begin
				result.valid = 1'b1;
				if (result.ready)
					state_d = BK_IDLE;
			end
			default:  state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q      <= job;
			res_mrpm_q <= '0;
			res_ums_q  <= '0;
			res_dist_q <= '0;
		end
		if (state_q == BK_MUL) begin
			prod_mrpm_q <= MRPM_NUM_W'(mag_d) * MRPM_NUM_W'(MRPM_SCALE);
			prod_dc_q   <= UMS_PROD_W'(mag_d) * UMS_PROD_W'(circ);
			prod_dist_q <= DIST_NUM_W'(mag_t) * DIST_NUM_W'(circ);
			den_q       <= DEN_W'(cpr) * DEN_W'(job_q.interval_ms);
		end
		if (state_q == BK_ROUND) begin
			rq_mrpm_q <= {1'b0, quo_mrpm} + (MRPM_NUM_W+1)'(up_mrpm);
			rq_ums_q  <= {1'b0, quo_ums} + (UMS_NUM_W+1)'(up_ums);
			rq_dist_q <= {1'b0, quo_dist} + (DIST_NUM_W+1)'(up_dist);
		end
		if (state_q == BK_SAT) begin
			res_mrpm_q <= sat_mrpm[SPEED_W-1:0];
			res_ums_q  <= sat_ums[SPEED_W-1:0];
			res_dist_q <= sat_dist;
		end
	end

	assign result.status          = job_q.status;
	assign result.result_channel  = job_q.channel;
	assign result.count_delta     = job_q.delta;
	assign result.count_total     = job_q.total;
	assign result.speed_milli_rpm = res_mrpm_q;
	assign result.speed_um_per_s  = res_ums_q;
	assign result.distance_um     = res_dist_q;

	// dividers are quiet whenever a new word can be taken
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_IDLE |-> !busy_mrpm && !busy_ums && !busy_dist)
		else $error("divider busy while back end idle");

	// only an updated word goes through the arithmetic
	a_upd_path: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready && job.status == ST_UPDATED |=> state_q == BK_MUL)
		else $error("updated word skipped the arithmetic");

	// skipped and cleared words carry no motion
	a_zero_res: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && job_q.status != ST_UPDATED |->
			res_mrpm_q == '0 && res_ums_q == '0 && res_dist_q == '0 && job_q.delta == '0)
		else $error("nonzero motion on a skipped or cleared word");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: drives encoder sample and clear words into the quadrature speed and
// distance estimator and checks every result word against an in-bench predictor
// depends on qsde_pkg, qsde_if and quadrature_speed_distance_estimator

module testbench;
	import qsde_pkg::*;

	// one sample channel word as the bench keeps it
	typedef struct {
		cmd_t                 command;
		logic                 channel;
		logic [COUNTER_W-1:0] counter_value;
		logic [MS_W-1:0]      interval_ms;
	} sample_word_t;

	// one expected result channel word
	typedef struct {
		status_t                   status;
		logic                      channel;
		logic signed [DELTA_W-1:0] delta;
		logic signed [TOTAL_W-1:0] total;
		logic signed [SPEED_W-1:0] mrpm;
		logic signed [SPEED_W-1:0] ums;
		logic signed [DIST_W-1:0]  dist_um;
	} motion_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	qsde_sample_if sample_ch ();
	qsde_result_if result_ch ();

	quadrature_speed_distance_estimator #(
		.NUM_CHANNELS(2)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor copy of the per-channel state and the settings
	logic [COUNTER_W-1:0] snap_model [2] = '{default: '0};
	logic [TOTAL_W-1:0]   total_model [2] = '{default: '0};
	logic [CPR_W-1:0]     cpr_reg  = '0;
	logic [CIRC_W-1:0]    circ_reg = '0;
	logic [ENA_W-1:0]     ena_reg  = '0;

	sample_word_t   sample_backlog [$];
	motion_result_t expected_motion [$];
	sample_word_t   offered;

	int words_queued   = 0;
	int words_accepted = 0;
	int results_taken  = 0;
	int mismatches     = 0;
	int src_gap        = 0;
	int hold_left      = 0;
	int stall_left     = 0;
	bit src_idle_on    = 1'b1;
	bit snk_idle_on    = 1'b1;

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// num / den rounded half away from zero, clipped to [-(lim+1), lim]
	function automatic logic [63:0] round_div_sat(longint num, longint unsigned den,
		longint unsigned lim);
		logic            neg;
		longint unsigned mag;
		longint unsigned quo;
		longint unsigned rem;
		neg = num < 0;
		if (neg)
			mag = -num;
		else
			mag = num;
		quo = mag / den;
		rem = mag % den;
		if (rem >= den - rem)
			quo++;
		if (neg) begin
			if (quo > lim + 1)
				quo = lim + 1;
			return -quo;
		end
		if (quo > lim)
			quo = lim;
		return quo;
	endfunction

	// applies one accepted word to the predictor state and returns its result
	function automatic motion_result_t advance_channel(sample_word_t w);
		motion_result_t  r;
		logic            on;
		logic [15:0]     step;
		longint unsigned den;
		longint          dl;
		longint          circ_l;
		longint          total_l;
		r.status  = ST_UPDATED;
		r.channel = w.channel;
		r.delta   = '0;
		r.mrpm    = '0;
		r.ums     = '0;
		r.dist_um = '0;
		on = ena_reg[w.channel];
		if (w.command == CMD_CLEAR) begin
			// a clear of a disabled channel leaves its state alone
			r.status = ST_CLEARED;
			if (on) begin
				snap_model[w.channel]  = '0;
				total_model[w.channel] = '0;
			end
		end else if (w.interval_ms == 0 || cpr_reg == 0) begin
			r.status = ST_INVALID;
		end else begin
			if (on) begin
				// counter difference wraps at 16 bits
				step = w.counter_value - snap_model[w.channel];
				r.delta = step;
				snap_model[w.channel]  = w.counter_value;
				total_model[w.channel] = total_model[w.channel] + {{16{step[15]}}, step};
			end
			den       = longint'(cpr_reg) * longint'(w.interval_ms);
			dl        = longint'(r.delta);
			circ_l    = longint'(circ_reg);
			total_l   = longint'(signed'(total_model[w.channel]));
			r.mrpm    = SPEED_W'(round_div_sat(dl * longint'(MRPM_SCALE), den, 64'(LIM32)));
			r.ums     = SPEED_W'(round_div_sat(dl * circ_l * longint'(UMS_SCALE), den,
				64'(LIM32)));
			r.dist_um = DIST_W'(round_div_sat(total_l * circ_l, longint'(cpr_reg),
				64'(LIM48)));
		end
		r.total = total_model[w.channel];
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at result word %0d: %s expected %h got %h",
				results_taken, what, want, got);
	endtask

	task automatic check_result();
		motion_result_t want;
		if (expected_motion.size() == 0) begin
			note_mismatch("word with nothing outstanding", '0, '0);
			return;
		end
		want = expected_motion.pop_front();
		if (result_ch.status !== want.status)
			note_mismatch("status", want.status, result_ch.status);
		if (result_ch.result_channel !== want.channel)
			note_mismatch("result_channel", want.channel, result_ch.result_channel);
		if (result_ch.count_delta !== want.delta)
			note_mismatch("count_delta", want.delta, result_ch.count_delta);
		if (result_ch.count_total !== want.total)
			note_mismatch("count_total", want.total, result_ch.count_total);
		if (result_ch.speed_milli_rpm !== want.mrpm)
			note_mismatch("speed_milli_rpm", want.mrpm, result_ch.speed_milli_rpm);
		if (result_ch.speed_um_per_s !== want.ums)
			note_mismatch("speed_um_per_s", want.ums, result_ch.speed_um_per_s);
		if (result_ch.distance_um !== want.dist_um)
			note_mismatch("distance_um", want.dist_um, result_ch.distance_um);
	endtask

	// sample driver: predicts on acceptance, then offers the next backlog word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid         <= 1'b0;
			sample_ch.command       <= 1'b0;
			sample_ch.channel       <= 1'b0;
			sample_ch.counter_value <= '0;
			sample_ch.interval_ms   <= '0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_motion.push_back(advance_channel(offered));
				words_accepted++;
			end
			// the slot is free when nothing is offered or the offer was just taken
			if (!sample_ch.valid || sample_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					sample_ch.valid <= 1'b0;
				end else if (sample_backlog.size() > 0) begin
					offered = sample_backlog.pop_front();
					sample_ch.valid         <= 1'b1;
					sample_ch.command       <= offered.command;
					sample_ch.channel       <= offered.channel;
					sample_ch.counter_value <= offered.counter_value;
					sample_ch.interval_ms   <= offered.interval_ms;
					src_gap = src_idle_on ? idle_gap() : 0;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each taken word and drives ready with stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				check_result();
				results_taken++;
				// two long hold-offs so the internal queue fills and the input stalls
				if (results_taken == 100 || results_taken == 300)
					hold_left = 400;
				else if (snk_idle_on)
					stall_left = idle_gap();
			end else if (snk_idle_on && result_ch.ready && $urandom_range(0, 15) == 0) begin
				stall_left = idle_gap();
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic queue_word(cmd_t c, logic ch, logic [COUNTER_W-1:0] cnt,
		logic [MS_W-1:0] ms);
		sample_word_t w;
		w.command       = c;
		w.channel       = ch;
		w.counter_value = cnt;
		w.interval_ms   = ms;
		sample_backlog.push_back(w);
		words_queued++;
	endtask

	// wait until every queued word is taken and answered
	task automatic drain();
		while (words_accepted != words_queued || expected_motion.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// settings change only while the block is idle
	task automatic apply_settings(logic [CPR_W-1:0] cpr, logic [CIRC_W-1:0] circ,
		logic [ENA_W-1:0] ena);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_CPR;
		cfg_wdata <= CFG_DATA_W'(cpr);
		@(posedge clk);
		cfg_index <= CFG_CIRC;
		cfg_wdata <= circ;
		@(posedge clk);
		cfg_index <= CFG_ENABLE;
		cfg_wdata <= CFG_DATA_W'(ena);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cpr_reg  = cpr;
		circ_reg = circ;
		ena_reg  = ena;
	endtask

	initial begin
		logic [COUNTER_W-1:0] pos [2];
		logic                 ch;
		logic [MS_W-1:0]      ms;
		int                   roll;
		int                   step;
		logic [CPR_W-1:0]     cpr;
		logic [CIRC_W-1:0]    circ;
		logic [ENA_W-1:0]     ena;

		// known values on every input before reset takes hold
		sample_ch.valid         = 1'b0;
		sample_ch.command       = 1'b0;
		sample_ch.channel       = 1'b0;
		sample_ch.counter_value = '0;
		sample_ch.interval_ms   = '0;
		result_ch.ready         = 1'b0;
		pos[0] = '0;
		pos[1] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings: counts per rev is zero so samples are skipped
		queue_word(CMD_SAMPLE, 1'b0, 16'h1234, 16'd10);
		queue_word(CMD_CLEAR, 1'b1, 16'hFFFF, 16'hFFFF);
		drain();

		// smallest cpr, widest wheel: speeds clip both ways, delta extremes
		apply_settings(16'd1, 24'hFFFFFF, 2'b11);
		queue_word(CMD_SAMPLE, 1'b0, 16'hFFFF, 16'd1);
		queue_word(CMD_SAMPLE, 1'b0, 16'h7FFF, 16'd1);
		queue_word(CMD_SAMPLE, 1'b0, 16'hFFFE, 16'hFFFF);
		queue_word(CMD_SAMPLE, 1'b1, 16'h8000, 16'd0);
		queue_word(CMD_SAMPLE, 1'b1, 16'h7FFF, 16'hFFFF);
		queue_word(CMD_CLEAR, 1'b0, 16'h0000, 16'h0000);
		drain();

		// largest cpr, zero circumference, channel 1 disabled while holding a total
		apply_settings(16'hFFFF, 24'd0, 2'b01);
		queue_word(CMD_SAMPLE, 1'b0, 16'h0001, 16'd1);
		queue_word(CMD_SAMPLE, 1'b1, 16'h5555, 16'd3);
		queue_word(CMD_CLEAR, 1'b1, 16'h0000, 16'h0000);
		queue_word(CMD_SAMPLE, 1'b0, 16'hAAAA, 16'hFFFF);
		drain();

		// halfway rounding on distance, disabled channel with a negative total
		apply_settings(16'd2, 24'd1, 2'b10);
		queue_word(CMD_SAMPLE, 1'b1, 16'h7FFF, 16'd7);
		queue_word(CMD_SAMPLE, 1'b1, 16'h7FFC, 16'd2);
		queue_word(CMD_SAMPLE, 1'b0, 16'h1234, 16'd5);
		drain();

		// random settings, mostly plausible motion with some noise
		for (int phase = 0; phase < 5; phase++) begin
			roll = $urandom_range(0, 9);
			if (roll == 0)
				cpr = '0;
			else if (roll == 1)
				cpr = 16'd1;
			else if (roll == 2)
				cpr = 16'hFFFF;
			else if (roll < 6)
				cpr = CPR_W'($urandom_range(1, 16));
			else
				cpr = CPR_W'($urandom_range(1, 65535));
			roll = $urandom_range(0, 9);
			if (roll == 0)
				circ = '0;
			else if (roll == 1)
				circ = 24'hFFFFFF;
			else if (roll < 5)
				circ = CIRC_W'($urandom_range(1, 1000));
			else
				circ = CIRC_W'($urandom);
			ena = ($urandom_range(0, 9) < 7) ? 2'b11 : 2'($urandom_range(0, 2));
			apply_settings(cpr, circ, ena);
			src_idle_on = ($urandom_range(0, 3) != 0);
			snk_idle_on = ($urandom_range(0, 3) != 0);
			for (int n = 0; n < 32; n++) begin
				ch   = 1'($urandom_range(0, 1));
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					queue_word(CMD_CLEAR, ch, COUNTER_W'($urandom), MS_W'($urandom));
					pos[ch] = '0;
				end else begin
					if (roll < 70) begin
						step = $urandom_range(0, 400) - 200;
						pos[ch] = pos[ch] + 16'(step);
					end else if (roll < 85) begin
						step = $urandom_range(0, 65535) - 32768;
						pos[ch] = pos[ch] + 16'(step);
					end else if (roll < 92) begin
						step = $urandom_range(0, 1) ? 32767 : -32768;
						pos[ch] = pos[ch] + 16'(step);
					end else begin
						// counter jump with no relation to the last snapshot
						pos[ch] = COUNTER_W'($urandom);
					end
					roll = $urandom_range(0, 99);
					if (roll < 4)
						ms = '0;
					else if (roll < 80)
						ms = MS_W'($urandom_range(1, 50));
					else
						ms = MS_W'($urandom);
					queue_word(CMD_SAMPLE, ch, pos[ch], ms);
				end
			end
			drain();
		end

		// steady forward run at full delta so the distance reaches its clip
		apply_settings(16'd1, 24'hFFFFFF, 2'b11);
		src_idle_on = ($urandom_range(0, 3) != 0);
		snk_idle_on = ($urandom_range(0, 3) != 0);
		queue_word(CMD_CLEAR, 1'b0, 16'h0000, 16'h0000);
		pos[0] = '0;
		for (int n = 0; n < 290; n++) begin
			ch = ($urandom_range(0, 9) == 0);
			if (ch) begin
				pos[1] = pos[1] + 16'($urandom_range(0, 400) - 200);
				queue_word(CMD_SAMPLE, 1'b1, pos[1], MS_W'($urandom_range(1, 65535)));
			end else begin
				pos[0] = pos[0] + 16'($urandom_range(32700, 32767));
				queue_word(CMD_SAMPLE, 1'b0, pos[0], MS_W'($urandom_range(1, 65535)));
			end
		end
		drain();

		// all settings back to zero by explicit writes
		apply_settings('0, '0, '0);
		queue_word(CMD_SAMPLE, 1'b0, 16'h0F0F, 16'd9);
		queue_word(CMD_CLEAR, 1'b0, 16'h0000, 16'h0000);
		queue_word(CMD_SAMPLE, 1'b1, 16'hF0F0, 16'd0);
		queue_word(CMD_CLEAR, 1'b1, 16'hFFFF, 16'hFFFF);
		drain();

		// allow a full update latency for any stray word
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
